// ===== sv/cbp_pkg.sv =====
// Shared types, register codes and counter helpers for the configurable branch predictor.
// No dependencies; imported by cbp_table, configurable_branch_predictor_top and tb_top.
`default_nettype none

package cbp_pkg;

   localparam int HIST_WIDTH  = 16;
   localparam int CFG_ADDR_W  = 5;
   localparam int CFG_DATA_W  = 32;
   localparam int CFG_FIELD_W = 5;
   localparam int KIND_W      = 2;
   localparam int RSP_CNT_W   = 32;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_KIND      = 3'd0;
   localparam logic [2:0] REG_BIM_BITS  = 3'd1;
   localparam logic [2:0] REG_GSH_BITS  = 3'd2;
   localparam logic [2:0] REG_HIST_BITS = 3'd3;
   localparam logic [2:0] REG_CHO_BITS  = 3'd4;

   // predictor_kind register codes; the fourth code behaves as bimodal
   localparam logic [KIND_W-1:0] KIND_BIMODAL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GSHARE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_HYBRID  = 2'd2;

   localparam logic [KIND_W-1:0]      RST_KIND      = KIND_BIMODAL;
   localparam logic [CFG_FIELD_W-1:0] RST_BIM_BITS  = 5'd12;
   localparam logic [CFG_FIELD_W-1:0] RST_GSH_BITS  = 5'd12;
   localparam logic [CFG_FIELD_W-1:0] RST_HIST_BITS = 5'd8;
   localparam logic [CFG_FIELD_W-1:0] RST_CHO_BITS  = 5'd12;
   localparam logic [CFG_FIELD_W-1:0] HIST_MAX      = 5'd16;

   typedef logic [1:0] ctr_type;

   localparam ctr_type CTR_WEAK_TAKEN   = 2'd2;
   localparam ctr_type CTR_WEAK_BIMODAL = 2'd1;
   localparam ctr_type CTR_MAX          = 2'd3;
   localparam ctr_type CTR_MIN          = 2'd0;

   // effective operating mode of one branch, settled when it is accepted
   typedef enum logic [1:0] {
      MODE_BIMODAL,
      MODE_GSHARE,
      MODE_HYBRID
   } mode_type;

   typedef struct packed {
      logic    rd_en;
      logic    wr_en;
      ctr_type wr_data;
      logic    clr_en;
   } tbl_ctl_type;

   function automatic ctr_type ctr_bump(ctr_type c, logic up);
      ctr_type r;
      r = c;
      if (up) begin
         if (c != CTR_MAX) r = c + 2'd1;
      end else begin
         if (c != CTR_MIN) r = c - 2'd1;
      end
      return r;
   endfunction

   function automatic logic [CFG_FIELD_W-1:0] cap_bits(logic [CFG_FIELD_W-1:0] v,
                                                        logic [CFG_FIELD_W-1:0] hi);
      return (v > hi) ? hi : v;
   endfunction

endpackage

`default_nettype wire

// ===== sv/configurable_branch_predictor_top.sv =====
// Bimodal / gshare / tournament branch predictor with APB-style control registers.
// Depends on cbp_pkg and cbp_table (three counter tables).
//
//   port group   dir   beat condition            carries
//   req_*        in    req_valid & req_ready     branch address, actual outcome
//   rsp_*        out   rsp_valid & rsp_ready     prediction, mispredict, chooser pick, counts
//   apb (p*)     in    psel & penable & pwrite   5 control registers at byte address 4*i
//
// One branch per cycle while rsp is not stalled; tables are read on the accept edge, and the
// update and result register follow on the edge at which the update stage advances.
// Each table is read on the accept edge and written back when the update stage advances; a
// one-entry bypass forwards that write to a branch whose read falls on the write-back edge.
// After reset the tables are swept to their initial values across 2**max(*_MAX_BITS) entries
// (65536 with defaults); req_ready stays low during the sweep.
// A stalled rsp holds the update stage, which in turn drops req_ready.
`default_nettype none

module configurable_branch_predictor_top import cbp_pkg::*; #(
   parameter int BIMODAL_MAX_BITS = 16,
   parameter int GSHARE_MAX_BITS  = 16,
   parameter int CHOOSER_MAX_BITS = 16,
   parameter int COUNT_WIDTH      = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [31:0]           req_branch_address,
   input  wire logic                  req_taken,

   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic                  rsp_predicted_taken,
   output      logic                  rsp_mispredicted,
   output      logic                  rsp_gshare_chosen,
   output      logic [RSP_CNT_W-1:0]  rsp_branches_seen,
   output      logic [RSP_CNT_W-1:0]  rsp_mispredictions_seen,

   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CFG_ADDR_W-1:0] paddr,
   input  wire logic [CFG_DATA_W-1:0] pwdata,
   output      logic [CFG_DATA_W-1:0] prdata,
   output      logic                  pready
);

   localparam int BW = BIMODAL_MAX_BITS;
   localparam int GW = GSHARE_MAX_BITS;
   localparam int CW = CHOOSER_MAX_BITS;
   localparam int BG_W  = (BW > GW) ? BW : GW;
   localparam int CLR_W = (BG_W > CW) ? BG_W : CW;

   localparam logic [CFG_FIELD_W-1:0] BIM_MAX = CFG_FIELD_W'(BW);
   localparam logic [CFG_FIELD_W-1:0] GSH_MAX = CFG_FIELD_W'(GW);
   localparam logic [CFG_FIELD_W-1:0] CHO_MAX = CFG_FIELD_W'(CW);

   localparam logic [BW-1:0]          BIM_ONES  = '1;
   localparam logic [GW-1:0]          GSH_ONES  = '1;
   localparam logic [CW-1:0]          CHO_ONES  = '1;
   localparam logic [HIST_WIDTH-1:0]  HIST_ONES = '1;
   localparam logic [COUNT_WIDTH-1:0] CNT_TOP   = '1;

   // ---------------- control registers ----------------
   logic [KIND_W-1:0]      kind_ff;
   logic [CFG_FIELD_W-1:0] bim_bits_ff, gsh_bits_ff, hist_bits_ff, cho_bits_ff;
   logic                   csr_wr;
   logic [2:0]             csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= RST_KIND;
         bim_bits_ff  <= RST_BIM_BITS;
         gsh_bits_ff  <= RST_GSH_BITS;
         hist_bits_ff <= RST_HIST_BITS;
         cho_bits_ff  <= RST_CHO_BITS;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_KIND:      kind_ff      <= pwdata[KIND_W-1:0];
            REG_BIM_BITS:  bim_bits_ff  <= pwdata[CFG_FIELD_W-1:0];
            REG_GSH_BITS:  gsh_bits_ff  <= pwdata[CFG_FIELD_W-1:0];
            REG_HIST_BITS: hist_bits_ff <= pwdata[CFG_FIELD_W-1:0];
            REG_CHO_BITS:  cho_bits_ff  <= pwdata[CFG_FIELD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_KIND:      prdata = CFG_DATA_W'(kind_ff);
         REG_BIM_BITS:  prdata = CFG_DATA_W'(bim_bits_ff);
         REG_GSH_BITS:  prdata = CFG_DATA_W'(gsh_bits_ff);
         REG_HIST_BITS: prdata = CFG_DATA_W'(hist_bits_ff);
         REG_CHO_BITS:  prdata = CFG_DATA_W'(cho_bits_ff);
         default:       prdata = '0;
      endcase
   end

   // ---------------- clear sweep ----------------
   logic             clr_ff;
   logic [CLR_W-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (&clr_addr_ff) clr_ff <= 1'b0;
      end
   end

   // ---------------- accept stage: mode and indexes ----------------
   logic                   accept;
   logic                   s1_go;
   logic                   s1_valid_ff;
   mode_type               s1_mode_ff;
   logic                   s1_taken_ff;
   logic                   rsp_valid_ff;

   logic [29:0]            pc;
   logic [CFG_FIELD_W-1:0] m_eff, n_eff, bim_eff, cho_eff, bim_w, low_w;
   mode_type               mode_in;
   logic [BW-1:0]          bi_idx;
   logic [GW-1:0]          gi_idx;
   logic [CW-1:0]          ci_idx;
   logic [HIST_WIDTH-1:0]  hist_ff, hist_in, hist_used;
   logic [31:0]            hist_pos;

   assign req_ready = !clr_ff && (!s1_valid_ff || s1_go);
   assign accept    = req_valid && req_ready;
   assign pc        = req_branch_address[31:2];

   always_comb begin
      m_eff   = cap_bits(gsh_bits_ff, GSH_MAX);
      n_eff   = cap_bits(cap_bits(hist_bits_ff, m_eff), HIST_MAX);
      bim_eff = cap_bits(bim_bits_ff, BIM_MAX);
      cho_eff = cap_bits(cho_bits_ff, CHO_MAX);
      low_w   = m_eff - n_eff;
      mode_in = MODE_BIMODAL;
      bim_w   = bim_eff;
      // zero history turns gshare into bimodal indexed with the gshare width
      if (kind_ff == KIND_GSHARE) begin
         if (n_eff == '0) bim_w = m_eff;
         else             mode_in = MODE_GSHARE;
      end else if (kind_ff == KIND_HYBRID && n_eff != '0) begin
         mode_in = MODE_HYBRID;
      end
   end

   always_comb begin
      hist_used = hist_ff & ~(HIST_ONES << n_eff);
      hist_pos  = 32'(hist_used) << low_w;
      bi_idx    = pc[BW-1:0] & ~(BIM_ONES << bim_w);
      gi_idx    = (pc[GW-1:0] & ~(GSH_ONES << m_eff)) ^ hist_pos[GW-1:0];
      ci_idx    = pc[CW-1:0] & ~(CHO_ONES << cho_eff);
      hist_in   = (hist_ff >> 1) | (HIST_WIDTH'(req_taken) << (n_eff - 5'd1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (accept && mode_in != MODE_BIMODAL) begin
         hist_ff <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff  <= mode_in;
         s1_taken_ff <= req_taken;
      end
   end

   // ---------------- counter tables ----------------
   tbl_ctl_type bim_ctl, gsh_ctl, cho_ctl;
   ctr_type     bim_cnt, gsh_cnt, cho_cnt;

   cbp_table #(.ADDR_W(BW), .INIT_VAL(CTR_WEAK_TAKEN)) u_bim (
      .clock(clock), .reset(reset), .ctl(bim_ctl), .rd_addr(bi_idx),
      .clr_addr(clr_addr_ff[BW-1:0]), .cnt(bim_cnt)
   );

   cbp_table #(.ADDR_W(GW), .INIT_VAL(CTR_WEAK_TAKEN)) u_gsh (
      .clock(clock), .reset(reset), .ctl(gsh_ctl), .rd_addr(gi_idx),
      .clr_addr(clr_addr_ff[GW-1:0]), .cnt(gsh_cnt)
   );

   cbp_table #(.ADDR_W(CW), .INIT_VAL(CTR_WEAK_BIMODAL)) u_cho (
      .clock(clock), .reset(reset), .ctl(cho_ctl), .rd_addr(ci_idx),
      .clr_addr(clr_addr_ff[CW-1:0]), .cnt(cho_cnt)
   );

   // ---------------- update stage ----------------
   logic pb, pg, pred, chose_g, bim_upd, gsh_upd, cho_upd, misp;

   assign s1_go = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pb    = bim_cnt[1];
   assign pg    = gsh_cnt[1];

   always_comb begin
      pred    = pb;
      chose_g = 1'b0;
      bim_upd = 1'b0;
      gsh_upd = 1'b0;
      cho_upd = 1'b0;
      case (s1_mode_ff)
         MODE_GSHARE: begin
            pred    = pg;
            gsh_upd = 1'b1;
         end
         MODE_HYBRID: begin
            chose_g = cho_cnt[1];
            pred    = cho_cnt[1] ? pg : pb;
            gsh_upd = cho_cnt[1];
            bim_upd = !cho_cnt[1];
            cho_upd = (pg != pb);
         end
         default: begin
            bim_upd = 1'b1;
         end
      endcase
      misp = (pred != s1_taken_ff);
   end

   always_comb begin
      bim_ctl.rd_en   = accept;
      bim_ctl.wr_en   = s1_go && bim_upd;
      bim_ctl.wr_data = ctr_bump(bim_cnt, s1_taken_ff);
      bim_ctl.clr_en  = clr_ff;
      gsh_ctl.rd_en   = accept;
      gsh_ctl.wr_en   = s1_go && gsh_upd;
      gsh_ctl.wr_data = ctr_bump(gsh_cnt, s1_taken_ff);
      gsh_ctl.clr_en  = clr_ff;
      cho_ctl.rd_en   = accept;
      cho_ctl.wr_en   = s1_go && cho_upd;
      cho_ctl.wr_data = ctr_bump(cho_cnt, pg == s1_taken_ff);
      cho_ctl.clr_en  = clr_ff;
   end

   // ---------------- running counts ----------------
   logic [COUNT_WIDTH-1:0] br_cnt_ff, br_cnt_in, misp_cnt_ff, misp_cnt_in;
   logic [63:0]            br_wide, misp_wide;

   always_comb begin
      br_cnt_in   = (br_cnt_ff == CNT_TOP) ? br_cnt_ff : br_cnt_ff + 1'b1;
      misp_cnt_in = misp_cnt_ff;
      if (misp && misp_cnt_ff != CNT_TOP) misp_cnt_in = misp_cnt_ff + 1'b1;
      br_wide   = 64'(br_cnt_in);
      misp_wide = 64'(misp_cnt_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         br_cnt_ff   <= '0;
         misp_cnt_ff <= '0;
      end else if (s1_go) begin
         br_cnt_ff   <= br_cnt_in;
         misp_cnt_ff <= misp_cnt_in;
      end
   end

   // ---------------- result register ----------------
   logic                 rsp_valid_in;
   logic                 rsp_pred_ff, rsp_misp_ff, rsp_chose_ff;
   logic [RSP_CNT_W-1:0] rsp_br_ff, rsp_misp_cnt_ff;

   assign rsp_valid_in = s1_go || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_pred_ff     <= pred;
         rsp_misp_ff     <= misp;
         rsp_chose_ff    <= chose_g;
         rsp_br_ff       <= br_wide[RSP_CNT_W-1:0];
         rsp_misp_cnt_ff <= misp_wide[RSP_CNT_W-1:0];
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_predicted_taken     = rsp_pred_ff;
   assign rsp_mispredicted        = rsp_misp_ff;
   assign rsp_gshare_chosen       = rsp_chose_ff;
   assign rsp_branches_seen       = rsp_br_ff;
   assign rsp_mispredictions_seen = rsp_misp_cnt_ff;

   // ---------------- checks ----------------
   a_misp_le_br: assert property (@(posedge clock) disable iff (reset)
      misp_cnt_ff <= br_cnt_ff)
      else $error("mispredict count exceeds branch count");

   a_no_work_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !s1_valid_ff && !accept)
      else $error("branch in flight during table sweep");

   a_chooser_agree: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_mode_ff == MODE_HYBRID && pg == pb |-> !cho_ctl.wr_en)
      else $error("chooser moved although both predictions agree");

   a_one_table: assert property (@(posedge clock) disable iff (reset)
      s1_go |-> $onehot({bim_ctl.wr_en, gsh_ctl.wr_en}))
      else $error("update stage must write exactly one prediction table");

   a_chose_hybrid_only: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_mode_ff != MODE_HYBRID |=> !rsp_gshare_chosen)
      else $error("chooser pick reported outside hybrid mode");

endmodule

`default_nettype wire

// ===== sv/cbp_table.sv =====
// One table of 2-bit counters in a synchronous RAM: registered read, write-back, clear sweep,
// and a bypass of the latest write. Depends on cbp_pkg.
`default_nettype none

module cbp_table import cbp_pkg::*; #(
   parameter int      ADDR_W   = 16,
   parameter ctr_type INIT_VAL = CTR_WEAK_TAKEN
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tbl_ctl_type       ctl,
   input  wire logic [ADDR_W-1:0] rd_addr,
   input  wire logic [ADDR_W-1:0] clr_addr,
   output      ctr_type           cnt
);

   localparam int DEPTH = 2 ** ADDR_W;

   ctr_type             mem [DEPTH];
   ctr_type             rd_data_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic                byp_valid_ff;
   logic [ADDR_W-1:0]   byp_addr_ff;
   ctr_type             byp_data_ff;

   // write-back goes to the entry read for the branch now in the update stage
   always_ff @(posedge clock) begin
      if (ctl.clr_en) begin
         mem[clr_addr] <= INIT_VAL;
      end else if (ctl.wr_en) begin
         mem[addr_ff] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         addr_ff    <= rd_addr;
      end
   end

   // the read of a beat issued on the same edge as the previous write-back sees old data
   always_ff @(posedge clock) begin
      if (reset || ctl.clr_en) begin
         byp_valid_ff <= 1'b0;
      end else if (ctl.wr_en) begin
         byp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         byp_addr_ff <= addr_ff;
         byp_data_ff <= ctl.wr_data;
      end
   end

   assign cnt = (byp_valid_ff && (byp_addr_ff == addr_ff)) ? byp_data_ff : rd_data_ff;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for configurable_branch_predictor_top.
// Depends on cbp_pkg and the predictor RTL; mirrors the counter tables, history and
// registers, and checks every response beat against its own prediction.
module tb_top import cbp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH      = 65536;
   localparam int MAX_IDX_BITS     = 16;
   localparam int CYCLE_LIMIT      = 400000;   // includes the table sweep after reset
   localparam int DRAIN_CYCLES     = 4;
   localparam int RANDOM_PER_PHASE = 80;
   localparam int POOL_SIZE        = 8;

   localparam logic [KIND_W-1:0] KIND_UNDEFINED  = 2'd3;
   localparam logic [2:0]        REG_SPARE_FIRST = 3'd5;
   localparam logic [2:0]        REG_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic        taken_pred;
      logic        miss;
      logic        gshare_pick;
      logic [31:0] seen;
      logic [31:0] missed;
   } prediction_type;

   logic                  clock               = 1'b0;
   logic                  reset               = 1'b1;
   logic                  req_valid           = 1'b0;
   logic                  req_ready;
   logic [31:0]           req_branch_address  = '0;
   logic                  req_taken           = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready           = 1'b0;
   logic                  rsp_predicted_taken;
   logic                  rsp_mispredicted;
   logic                  rsp_gshare_chosen;
   logic [RSP_CNT_W-1:0]  rsp_branches_seen;
   logic [RSP_CNT_W-1:0]  rsp_mispredictions_seen;
   logic                  psel                = 1'b0;
   logic                  penable             = 1'b0;
   logic                  pwrite              = 1'b0;
   logic [CFG_ADDR_W-1:0] paddr               = '0;
   logic [CFG_DATA_W-1:0] pwdata              = '0;
   logic [CFG_DATA_W-1:0] prdata;
   logic                  pready;

   configurable_branch_predictor_top dut (.*);

   // predictor mirror
   logic [1:0]        bim_ctr [TABLE_DEPTH];
   logic [1:0]        gsh_ctr [TABLE_DEPTH];
   logic [1:0]        cho_ctr [TABLE_DEPTH];
   logic [15:0]       ghist;
   logic [31:0]       seen_count;
   logic [31:0]       miss_count;
   logic [KIND_W-1:0] cfg_kind;
   logic [4:0]        cfg_bim_bits;
   logic [4:0]        cfg_gsh_bits;
   logic [4:0]        cfg_hist_bits;
   logic [4:0]        cfg_cho_bits;

   prediction_type expected_q[$];

   int          idle_pct    = 0;
   int          stall_pct   = 0;
   int          error_count = 0;
   int unsigned cycle_count = 0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int unsigned clamp(int unsigned v, int unsigned hi);
      return (v > hi) ? hi : v;
   endfunction

   function automatic int unsigned low_bits(int unsigned v, int unsigned bits);
      return (bits == 0) ? 0 : (v & ((32'd1 << bits) - 1));
   endfunction

   function automatic logic [1:0] step_ctr(logic [1:0] c, logic up);
      if (up) return (c == 2'd3) ? c : c + 2'd1;
      return (c == 2'd0) ? c : c - 2'd1;
   endfunction

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
         error_count++;
      end
   endtask

   task automatic reset_model();
      foreach (bim_ctr[i]) begin
         bim_ctr[i] = CTR_WEAK_TAKEN;
         gsh_ctr[i] = CTR_WEAK_TAKEN;
         cho_ctr[i] = CTR_WEAK_BIMODAL;
      end
      ghist         = '0;
      seen_count    = '0;
      miss_count    = '0;
      cfg_kind      = RST_KIND;
      cfg_bim_bits  = RST_BIM_BITS;
      cfg_gsh_bits  = RST_GSH_BITS;
      cfg_hist_bits = RST_HIST_BITS;
      cfg_cho_bits  = RST_CHO_BITS;
   endtask

   // works out the response for one branch and updates the mirrored state
   task automatic predict_branch(input logic [31:0] addr, input logic tk);
      int unsigned pc, m, n, bi, gi, ci, low_w, idx, mixed;
      logic        pg, pb, pred, chose;
      mode_type    mode;
      pc    = addr >> 2;
      m     = clamp(cfg_gsh_bits, MAX_IDX_BITS);
      n     = clamp(cfg_hist_bits, m);
      chose = 1'b0;
      bi    = low_bits(pc, clamp(cfg_bim_bits, MAX_IDX_BITS));
      ci    = low_bits(pc, clamp(cfg_cho_bits, MAX_IDX_BITS));
      mode  = MODE_BIMODAL;
      if (n != 0 && cfg_kind == KIND_GSHARE) mode = MODE_GSHARE;
      else if (n != 0 && cfg_kind == KIND_HYBRID) mode = MODE_HYBRID;
      else if (cfg_kind == KIND_GSHARE) bi = low_bits(pc, m);  // no history: gshare width
      low_w = m - n;
      idx   = low_bits(pc, m);
      mixed = (idx >> low_w) ^ low_bits(ghist, n);
      gi    = low_bits((mixed << low_w) | low_bits(idx, low_w), m);
      pg    = gsh_ctr[gi][1];
      pb    = bim_ctr[bi][1];
      case (mode)
         MODE_GSHARE: begin
            pred = pg;
            gsh_ctr[gi] = step_ctr(gsh_ctr[gi], tk);
         end
         MODE_HYBRID: begin
            chose = cho_ctr[ci][1];
            pred  = chose ? pg : pb;
            if (chose) gsh_ctr[gi] = step_ctr(gsh_ctr[gi], tk);
            else bim_ctr[bi] = step_ctr(bim_ctr[bi], tk);
            if (pg != pb) cho_ctr[ci] = step_ctr(cho_ctr[ci], pg == tk);
         end
         default: begin
            pred = pb;
            bim_ctr[bi] = step_ctr(bim_ctr[bi], tk);
         end
      endcase
      if (mode != MODE_BIMODAL) ghist = (ghist >> 1) | (16'(tk) << (n - 1));
      if (seen_count != '1) seen_count++;
      if (pred != tk && miss_count != '1) miss_count++;
      expected_q.push_back('{pred, pred != tk, chose, seen_count, miss_count});
   endtask

   // one APB transfer; called at a rising edge, drops psel and penable after the access edge and returns
   task automatic apb_transfer(input logic wr, input logic [2:0] reg_idx,
                               input logic [31:0] wdata, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] reg_idx, input logic [31:0] value);
      logic [31:0] unused_rd;
      apb_transfer(1'b1, reg_idx, value, unused_rd);
      case (reg_idx)
         REG_KIND:      cfg_kind      = value[KIND_W-1:0];
         REG_BIM_BITS:  cfg_bim_bits  = value[4:0];
         REG_GSH_BITS:  cfg_gsh_bits  = value[4:0];
         REG_HIST_BITS: cfg_hist_bits = value[4:0];
         REG_CHO_BITS:  cfg_cho_bits  = value[4:0];
         default: ;
      endcase
   endtask

   task automatic check_regs();
      logic [31:0] got, want;
      for (int i = REG_KIND; i <= REG_CHO_BITS; i++) begin
         apb_transfer(1'b0, 3'(i), '0, got);
         case (3'(i))
            REG_KIND:      want = 32'(cfg_kind);
            REG_BIM_BITS:  want = 32'(cfg_bim_bits);
            REG_GSH_BITS:  want = 32'(cfg_gsh_bits);
            REG_HIST_BITS: want = 32'(cfg_hist_bits);
            default:       want = 32'(cfg_cho_bits);
         endcase
         check_field("register read", want, got);
      end
   endtask

   // stop sending and let every outstanding beat come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_predictor(input logic [KIND_W-1:0] kind, input int unsigned bim,
                                    input int unsigned gsh, input int unsigned hist,
                                    input int unsigned cho);
      wait_idle();
      write_reg(REG_KIND, 32'(kind));
      write_reg(REG_BIM_BITS, bim);
      write_reg(REG_GSH_BITS, gsh);
      write_reg(REG_HIST_BITS, hist);
      write_reg(REG_CHO_BITS, cho);
   endtask

   task automatic send_branch(input logic [31:0] addr, input logic tk);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_branch_address <= addr;
      req_taken          <= tk;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_branch(addr, tk);
   endtask

   // mostly loop-like branches from a small pool (some aliasing in every table),
   // the rest fully random addresses and outcomes
   task automatic run_branch_stream(input int count, input int pause_at);
      logic [31:0] pool_addr [POOL_SIZE];
      int unsigned pool_period [POOL_SIZE];
      int unsigned pool_iter [POOL_SIZE];
      int          k;
      logic [31:0] addr;
      logic        tk;
      for (int p = 0; p < POOL_SIZE; p++) begin
         pool_addr[p]   = (p % 2 == 1) ? pool_addr[p-1] ^ ($urandom() << 18) : $urandom();
         pool_period[p] = $urandom_range(1, 6);
         pool_iter[p]   = 0;
      end
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) wait_idle();
         if ($urandom_range(99) < 75) begin
            k    = $urandom_range(POOL_SIZE - 1);
            addr = pool_addr[k];
            tk   = (pool_iter[k] % (pool_period[k] + 1)) != pool_period[k];
            pool_iter[k]++;
            if ($urandom_range(99) < 5) tk = ~tk;
         end else begin
            addr = $urandom();
            tk   = $urandom_range(1);
         end
         send_branch(addr, tk);
      end
   endtask

   always @(posedge clock) begin : result_check
      prediction_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: response beat with no branch outstanding", $time);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            check_field("predicted_taken", 32'(want.taken_pred), 32'(rsp_predicted_taken));
            check_field("mispredicted", 32'(want.miss), 32'(rsp_mispredicted));
            check_field("gshare_chosen", 32'(want.gshare_pick), 32'(rsp_gshare_chosen));
            check_field("branches_seen", want.seen, rsp_branches_seen);
            check_field("mispredictions_seen", want.missed, rsp_mispredictions_seen);
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // reset configuration: bimodal, 12 index bits
   task automatic test_reset_defaults();
      check_regs();
      send_branch(32'h0000_0000, 1'b0);
      send_branch(32'h0000_0003, 1'b0);   // same counter back to back
      send_branch(32'hFFFF_C000, 1'b1);   // aliases entry 0
      send_branch(32'hFFFF_FFFF, 1'b1);
      send_branch(32'hFFFF_FFFF, 1'b1);
      send_branch(32'hFFFF_FFFF, 1'b1);   // saturates high
      send_branch(32'hFFFF_FFFF, 1'b0);
   endtask

   // junk above each field must be dropped; writes past the last register do nothing
   task automatic test_register_access();
      wait_idle();
      write_reg(REG_KIND, ($urandom() & ~32'h3) | 32'(KIND_GSHARE));
      write_reg(REG_BIM_BITS, ($urandom() & ~32'h1F) | 32'd3);
      write_reg(REG_GSH_BITS, ($urandom() & ~32'h1F) | 32'd6);
      write_reg(REG_HIST_BITS, ($urandom() & ~32'h1F) | 32'd4);
      write_reg(REG_CHO_BITS, ($urandom() & ~32'h1F) | 32'd2);
      for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++) write_reg(3'(i), $urandom());
      check_regs();
      send_branch($urandom(), 1'b1);
      send_branch($urandom(), 1'b0);
   endtask

   task automatic test_special_modes();
      // gshare without history falls back to the bimodal table at gshare width
      program_predictor(KIND_GSHARE, 12, 4, 0, 12);
      send_branch(32'h0000_0040, 1'b0);
      send_branch(32'h0000_0040, 1'b0);
      // hybrid without history is plain bimodal at bimodal width
      program_predictor(KIND_HYBRID, 2, 12, 0, 12);
      send_branch(32'h0000_0014, 1'b1);
      send_branch(32'h0000_0014, 1'b1);
      program_predictor(KIND_UNDEFINED, 12, 12, 8, 12);
      send_branch($urandom(), 1'b0);
      send_branch($urandom(), 1'b1);
      // oversized widths clip to the table size; zero width is a single entry
      program_predictor(KIND_HYBRID, 31, 20, 31, 0);
      send_branch($urandom(), 1'b0);
      send_branch($urandom(), 1'b1);
      program_predictor(KIND_GSHARE, 0, 0, 5, 0);
      send_branch($urandom(), 1'b0);
      send_branch($urandom(), 1'b0);
      program_predictor(KIND_HYBRID, 0, 3, 3, 0);
      send_branch($urandom(), 1'b1);
      send_branch($urandom(), 1'b0);
      // history longer than the index clips to the index width
      program_predictor(KIND_GSHARE, 12, 6, 20, 12);
      send_branch(32'h0000_1234, 1'b1);
      send_branch(32'h0000_1234, 1'b1);
      send_branch(32'h0000_1234, 1'b1);
      // shorter history afterwards: the upper history bits stay but are not used
      program_predictor(KIND_GSHARE, 12, 6, 2, 12);
      send_branch(32'h0000_1234, 1'b0);
      send_branch(32'h0000_1234, 1'b1);
   endtask

   task automatic test_random_phases();
      program_predictor(KIND_HYBRID, 12, 12, 8, 12);
      idle_pct  = 0;
      stall_pct = 0;
      run_branch_stream(RANDOM_PER_PHASE, -1);

      program_predictor(KIND_GSHARE, 16, 16, 16, 16);
      idle_pct  = 48;
      stall_pct = 0;
      run_branch_stream(RANDOM_PER_PHASE, -1);

      program_predictor(KIND_HYBRID, 1, 2, 2, 1);
      idle_pct  = 0;
      stall_pct = 48;
      run_branch_stream(RANDOM_PER_PHASE, -1);

      // pauses halfway until the pipe is empty
      program_predictor(KIND_HYBRID, 16, 5, 3, 16);
      idle_pct  = 16;
      stall_pct = 16;
      run_branch_stream(RANDOM_PER_PHASE, RANDOM_PER_PHASE / 2);

      program_predictor($urandom_range(3), $urandom_range(31), $urandom_range(31),
                        $urandom_range(31), $urandom_range(31));
      run_branch_stream(RANDOM_PER_PHASE / 2, -1);
   endtask

   initial begin
      reset_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (!req_ready) @(posedge clock);   // table sweep
      test_reset_defaults();
      test_register_access();
      test_special_modes();
      test_random_phases();
      wait_idle();
      if (error_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
